FILE: rtl/mlpbt_pkg.sv
// Shared types, constants and the sigmoid table of the backpropagation trainer.
package mlpbt_pkg;

	localparam int MAX_LAYERS      = 4;
	localparam int MAX_NEURONS     = 8;
	localparam int WEIGHT_DEPTH    = 256;
	localparam int SIGMOID_ENTRIES = 256;

	localparam int LAY_W      = $clog2(MAX_LAYERS);
	localparam int NEU_W      = $clog2(MAX_NEURONS);
	localparam int SZ_W       = 4;
	localparam int WA_W       = $clog2(WEIGHT_DEPTH);
	localparam int AA_W       = LAY_W + NEU_W;
	localparam int ACT_DEPTH  = MAX_LAYERS * MAX_NEURONS;
	localparam int SIG_W      = $clog2(SIGMOID_ENTRIES);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [2:0] {
		ACT_WR_WEIGHT = 3'd0,
		ACT_WR_INPUT  = 3'd1,
		ACT_WR_TARGET = 3'd2,
		ACT_RUN       = 3'd3,
		ACT_TRAIN     = 3'd4,
		ACT_RD_WEIGHT = 3'd5
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LAYER_COUNT   = 3'd0,
		CFG_SIZE_ZERO     = 3'd1,
		CFG_SIZE_ONE      = 3'd2,
		CFG_SIZE_TWO      = 3'd3,
		CFG_SIZE_THREE    = 3'd4,
		CFG_LEARNING_RATE = 3'd5,
		CFG_DESIRED_ERROR = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MUL_AW, MUL_DW, MUL_SLOPE, MUL_EG, MUL_SG, MUL_AD, MUL_PL
	} mul_sel_t;

	typedef enum logic [1:0] {
		OUT_WEIGHT, OUT_RUN, OUT_TRAIN
	} out_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RW_RD, ST_RW_OUT,
		ST_F_RD, ST_F_MUL, ST_F_ACC, ST_F_NET, ST_F_WR,
		ST_O_RD, ST_O_MUL, ST_O_G, ST_O_MUL2, ST_O_WR,
		ST_H_RD, ST_H_MUL, ST_H_ACC, ST_H_S, ST_H_MUL2, ST_H_G, ST_H_MUL3, ST_H_WR,
		ST_U_RD, ST_U_MUL, ST_U_MUL2, ST_U_WR,
		ST_EM_RD, ST_EM_OUT
	} state_t;

	typedef struct packed {
		logic                 mul_en;
		mul_sel_t             mul_sel;
		logic                 acc_clr;
		logic                 acc_en;
		logic                 sat_en;
		logic                 g_en;
		logic                 e_en;
		logic                 conv_clr;
		logic                 act_we;
		logic                 act_from_item;
		logic [AA_W-1:0]      act_waddr;
		logic [AA_W-1:0]      act_raddr;
		logic                 dlt_we;
		logic [AA_W-1:0]      dlt_waddr;
		logic [AA_W-1:0]      dlt_raddr;
		logic                 w_we;
		logic                 w_from_item;
		logic [WA_W-1:0]      w_addr;
		logic                 tgt_we;
		logic [NEU_W-1:0]     nidx;
		logic [15:0]          item_value;
		logic                 out_ld;
		out_sel_t             out_sel;
		logic                 out_last;
		logic [16:0]          lr;
		logic [12:0]          derr;
	} dp_cmd_t;

	typedef logic [15:0] sig_tab_t [SIGMOID_ENTRIES];

	// shift-subtract quotient, used only while the table is built
	function automatic longint unsigned udiv(input longint unsigned num,
			input longint unsigned dvs);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= dvs) begin
				r    = r - dvs;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// round(4096 / (1 + exp(-x))) at the bucket centre, exp by series at x/16 then squared
	function automatic logic [15:0] sig_entry(input int unsigned i);
		longint            x;
		longint            sum;
		longint unsigned   mag;
		longint unsigned   u;
		longint unsigned   term;
		longint unsigned   s;
		longint unsigned   den;
		longint unsigned   p;
		x = longint'(-32768) + ((longint'(2 * i + 1) * 32768) >>> SIG_W);
		mag = unsigned'((x < 0) ? -x : x);
		u = mag << 14;
		term = 64'd1 << 30;
		sum = longint'(term);
		for (int n = 1; n <= 12; n++) begin
			term = udiv((term * u) >> 30, 64'(n));
			if ((n & 1) != 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		s = unsigned'(sum);
		for (int n = 0; n < 4; n++) begin
			s = (s * s) >> 30;
		end
		den = (64'd1 << 30) + s;
		p = udiv((64'd4096 << 30) + (den >> 1), den);
		if (x < 0) begin
			p = 64'd4096 - p;
		end
		return p[15:0];
	endfunction

	function automatic sig_tab_t build_sig_table();
		sig_tab_t t;
		for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
			t[i] = sig_entry(unsigned'(i));
		end
		return t;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

FILE: rtl/mlpbt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module mlpbt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/mlpbt_dp.sv
// Datapath: weight, activation and delta stores, shared multiplier, accumulator, result register.
module mlpbt_dp import mlpbt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output logic [2:0]         out_index,
	output logic signed [15:0] out_value,
	output logic signed [13:0] out_error,
	output logic               converged,
	output logic               last_result
);

	logic [15:0]        w_rd;
	logic [15:0]        act_rd;
	logic [15:0]        dlt_rd;
	logic [15:0]        w_wdata;
	logic [15:0]        act_wdata;
	logic [15:0]        dlt_wdata;

	logic signed [39:0] acc_q;
	logic signed [50:0] prod_q;
	logic signed [15:0] s_q;
	logic signed [17:0] g_q;
	logic signed [13:0] e_q;
	logic               conv_q;
	logic signed [13:0] err_q [MAX_NEURONS];
	logic [15:0]        tgt_q [MAX_NEURONS];

	logic [2:0]         out_index_q;
	logic [15:0]        out_value_q;
	logic [13:0]        out_error_q;
	logic               converged_q;
	logic               last_q;

	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [50:0] prod_d;
	logic signed [16:0] diff;
	logic signed [13:0] e_d;
	logic [13:0]        e_abs;
	logic               e_ok;
	logic [15:0]        s_bias;
	logic [SIG_W-1:0]   sig_idx;
	logic signed [50:0] w_sum;

	localparam logic signed [17:0] ONE_Q = 18'sd4096;

	function automatic logic [15:0] sat16(input logic signed [50:0] v);
		if (v > 51'sd32767) begin
			return 16'h7FFF;
		end else if (v < -51'sd32768) begin
			return 16'h8000;
		end else begin
			return v[15:0];
		end
	endfunction

	mlpbt_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_w_ram (
		.clk  (clk),
		.we   (cmd.w_we),
		.waddr(cmd.w_addr),
		.wdata(w_wdata),
		.raddr(cmd.w_addr),
		.rdata(w_rd)
	);

	mlpbt_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_act_ram (
		.clk  (clk),
		.we   (cmd.act_we),
		.waddr(cmd.act_waddr),
		.wdata(act_wdata),
		.raddr(cmd.act_raddr),
		.rdata(act_rd)
	);

	mlpbt_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_dlt_ram (
		.clk  (clk),
		.we   (cmd.dlt_we),
		.waddr(cmd.dlt_waddr),
		.wdata(dlt_wdata),
		.raddr(cmd.dlt_raddr),
		.rdata(dlt_rd)
	);

	always_comb begin
		mul_a = {{17{act_rd[15]}}, act_rd};
		mul_b = {{2{w_rd[15]}}, w_rd};
		unique case (cmd.mul_sel)
			MUL_AW: begin
				mul_a = {{17{act_rd[15]}}, act_rd};
				mul_b = {{2{w_rd[15]}}, w_rd};
			end
			MUL_DW: begin
				mul_a = {{17{dlt_rd[15]}}, dlt_rd};
				mul_b = {{2{w_rd[15]}}, w_rd};
			end
			MUL_SLOPE: begin
				mul_a = {{17{act_rd[15]}}, act_rd};
				mul_b = ONE_Q - signed'({{2{act_rd[15]}}, act_rd});
			end
			MUL_EG: begin
				mul_a = {{19{e_q[13]}}, e_q};
				mul_b = g_q;
			end
			MUL_SG: begin
				mul_a = {{17{s_q[15]}}, s_q};
				mul_b = g_q;
			end
			MUL_AD: begin
				mul_a = {{17{act_rd[15]}}, act_rd};
				mul_b = {{2{dlt_rd[15]}}, dlt_rd};
			end
			MUL_PL: begin
				mul_a = prod_q[32:0];
				mul_b = {1'b0, cmd.lr};
			end
			default: ;
		endcase
	end

	assign prod_d = 51'(mul_a) * 51'(mul_b);

	// output error, saturated to one unit either way
	always_comb begin
		diff = signed'({tgt_q[cmd.nidx][15], tgt_q[cmd.nidx]}) - signed'({act_rd[15], act_rd});
		if (diff > 17'sd4096) begin
			e_d = 14'sd4096;
		end else if (diff < -17'sd4096) begin
			e_d = -14'sd4096;
		end else begin
			e_d = diff[13:0];
		end
		e_abs = e_d[13] ? 14'(-e_d) : 14'(e_d);
		e_ok  = (e_d == 14'sd0) || (e_abs < {1'b0, cmd.derr});
	end

	assign s_bias    = s_q ^ 16'h8000;
	assign sig_idx   = s_bias[15 -: SIG_W];
	assign w_sum     = 51'(signed'(w_rd)) + (prod_q >>> 28);
	assign w_wdata   = cmd.w_from_item ? cmd.item_value : sat16(w_sum);
	assign act_wdata = cmd.act_from_item ? cmd.item_value : SIG_TABLE[sig_idx];
	assign dlt_wdata = sat16(prod_q >>> 12);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_q <= 1'b1;
		end else begin
			if (cmd.conv_clr) begin
				conv_q <= 1'b1;
			end else if (cmd.e_en && !e_ok) begin
				conv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= prod_d;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + 40'(prod_q);
		end
		if (cmd.sat_en) begin
			s_q <= sat16(51'(acc_q >>> 12));
		end
		if (cmd.g_en) begin
			g_q <= 18'(prod_q >>> 12);
		end
		if (cmd.e_en) begin
			e_q <= e_d;
			err_q[cmd.nidx] <= e_d;
		end
		if (cmd.tgt_we) begin
			tgt_q[cmd.nidx] <= cmd.item_value;
		end
		if (cmd.out_ld) begin
			last_q <= cmd.out_last;
			unique case (cmd.out_sel)
				OUT_WEIGHT: begin
					out_index_q <= '0;
					out_value_q <= w_rd;
					out_error_q <= '0;
					converged_q <= 1'b0;
				end
				OUT_RUN: begin
					out_index_q <= cmd.nidx;
					out_value_q <= act_rd;
					out_error_q <= '0;
					converged_q <= 1'b0;
				end
				OUT_TRAIN: begin
					out_index_q <= cmd.nidx;
					out_value_q <= act_rd;
					out_error_q <= err_q[cmd.nidx];
					converged_q <= conv_q;
				end
				default: ;
			endcase
		end
	end

	assign out_index   = out_index_q;
	assign out_value   = out_value_q;
	assign out_error   = out_error_q;
	assign converged   = converged_q;
	assign last_result = last_q;

endmodule

FILE: rtl/mlpbt_ctrl.sv
// Controller: configuration registers, network shape, loop counters and sequencing state machine.
module mlpbt_ctrl import mlpbt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            action,
	input  logic [7:0]            item_index,
	input  logic signed [15:0]    item_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output dp_cmd_t               cmd
);

	state_t            state_q, state_d;
	logic [LAY_W-1:0]  lay_q, lay_d;
	logic [NEU_W-1:0]  j_q, j_d;
	logic [NEU_W-1:0]  k_q, k_d;
	logic              train_q, train_d;
	logic [7:0]        idx_q;
	logic              out_valid_q;

	logic [2:0]        layer_count_q;
	logic [SZ_W-1:0]   size_q [MAX_LAYERS];
	logic [16:0]       lr_q;
	logic [12:0]       derr_q;

	logic [SZ_W-1:0]   sz_c [MAX_LAYERS];
	logic [WA_W-1:0]   base_c [MAX_LAYERS];
	logic [LAY_W-1:0]  olay_c;
	logic [16:0]       lr_c;
	logic [LAY_W-1:0]  lm1;
	logic [LAY_W-1:0]  lp1;
	logic [LAY_W-1:0]  wa_blay;
	logic [NEU_W-1:0]  wa_row;
	logic [NEU_W-1:0]  wa_col;
	logic [WA_W-1:0]   wa_c;
	logic              out_free;

	function automatic logic [SZ_W-1:0] clamp_sz(input logic [SZ_W-1:0] v);
		if (v == '0) begin
			return SZ_W'(1);
		end else if (v > SZ_W'(MAX_NEURONS)) begin
			return SZ_W'(MAX_NEURONS);
		end else begin
			return v;
		end
	endfunction

	function automatic logic is_last(input logic [NEU_W-1:0] c, input logic [SZ_W-1:0] n);
		return c == NEU_W'(n - SZ_W'(1));
	endfunction

	always_comb begin
		for (int p = 0; p < MAX_LAYERS; p++) begin
			sz_c[p] = clamp_sz(size_q[p]);
		end
		base_c[0] = '0;
		for (int p = 1; p < MAX_LAYERS; p++) begin
			base_c[p] = base_c[p-1] + WA_W'(WA_W'(sz_c[p-1]) * WA_W'(sz_c[p]));
		end
		if (layer_count_q < 3'd2) begin
			olay_c = LAY_W'(1);
		end else if (layer_count_q > 3'(MAX_LAYERS)) begin
			olay_c = LAY_W'(MAX_LAYERS - 1);
		end else begin
			olay_c = LAY_W'(layer_count_q - 3'd1);
		end
		lr_c = (lr_q > 17'd65536) ? 17'd65536 : lr_q;
	end

	assign lm1 = lay_q - LAY_W'(1);
	assign lp1 = lay_q + LAY_W'(1);

	// weight address: base of the layer pair, row times destination size, plus column
	always_comb begin
		if (state_q == ST_H_RD || state_q == ST_H_MUL) begin
			wa_blay = lay_q;
			wa_row  = j_q;
			wa_col  = k_q;
		end else begin
			wa_blay = lm1;
			wa_row  = k_q;
			wa_col  = j_q;
		end
		wa_c = base_c[wa_blay]
			+ WA_W'(WA_W'(wa_row) * WA_W'(sz_c[LAY_W'(wa_blay + LAY_W'(1))]))
			+ WA_W'(wa_col);
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		lay_d   = lay_q;
		j_d     = j_q;
		k_d     = k_q;
		train_d = train_q;

		cmd            = '0;
		cmd.mul_sel    = MUL_AW;
		cmd.out_sel    = OUT_RUN;
		cmd.w_addr     = item_index;
		cmd.item_value = item_value;
		cmd.lr         = lr_c;
		cmd.derr       = derr_q;
		cmd.nidx       = j_q;
		cmd.act_waddr  = {lay_q, j_q};
		cmd.act_raddr  = {olay_c, j_q};
		cmd.dlt_waddr  = {lay_q, j_q};
		cmd.dlt_raddr  = {lay_q, j_q};

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (action)
						ACT_WR_WEIGHT: begin
							cmd.w_we        = 1'b1;
							cmd.w_from_item = 1'b1;
						end
						ACT_WR_INPUT: begin
							if (item_index < 8'(MAX_NEURONS)) begin
								cmd.act_we        = 1'b1;
								cmd.act_from_item = 1'b1;
								cmd.act_waddr     = {LAY_W'(0), item_index[NEU_W-1:0]};
							end
						end
						ACT_WR_TARGET: begin
							if (item_index < 8'(MAX_NEURONS)) begin
								cmd.tgt_we = 1'b1;
								cmd.nidx   = item_index[NEU_W-1:0];
							end
						end
						ACT_RUN, ACT_TRAIN: begin
							lay_d        = LAY_W'(1);
							j_d          = '0;
							k_d          = '0;
							cmd.acc_clr  = 1'b1;
							cmd.conv_clr = 1'b1;
							train_d      = (action == ACT_TRAIN);
							state_d      = ST_F_RD;
						end
						ACT_RD_WEIGHT: begin
							state_d = ST_RW_RD;
						end
						default: ;
					endcase
				end
			end
			ST_RW_RD: begin
				cmd.w_addr = idx_q;
				state_d    = ST_RW_OUT;
			end
			ST_RW_OUT: begin
				cmd.w_addr = idx_q;
				if (out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_sel  = OUT_WEIGHT;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_F_RD: begin
				cmd.act_raddr = {lm1, k_q};
				cmd.w_addr    = wa_c;
				state_d       = ST_F_MUL;
			end
			ST_F_MUL: begin
				cmd.act_raddr = {lm1, k_q};
				cmd.w_addr    = wa_c;
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_AW;
				state_d       = ST_F_ACC;
			end
			ST_F_ACC: begin
				cmd.acc_en = 1'b1;
				if (is_last(k_q, sz_c[lm1])) begin
					state_d = ST_F_NET;
				end else begin
					k_d     = k_q + NEU_W'(1);
					state_d = ST_F_RD;
				end
			end
			ST_F_NET: begin
				cmd.sat_en = 1'b1;
				state_d    = ST_F_WR;
			end
			ST_F_WR: begin
				cmd.act_we  = 1'b1;
				cmd.acc_clr = 1'b1;
				k_d         = '0;
				if (is_last(j_q, sz_c[lay_q])) begin
					j_d = '0;
					if (lay_q == olay_c) begin
						state_d = train_q ? ST_O_RD : ST_EM_RD;
					end else begin
						lay_d   = lp1;
						state_d = ST_F_RD;
					end
				end else begin
					j_d     = j_q + NEU_W'(1);
					state_d = ST_F_RD;
				end
			end
			ST_O_RD: begin
				state_d = ST_O_MUL;
			end
			ST_O_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SLOPE;
				cmd.e_en    = 1'b1;
				state_d     = ST_O_G;
			end
			ST_O_G: begin
				cmd.g_en = 1'b1;
				state_d  = ST_O_MUL2;
			end
			ST_O_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_EG;
				state_d     = ST_O_WR;
			end
			ST_O_WR: begin
				cmd.dlt_we    = 1'b1;
				cmd.dlt_waddr = {olay_c, j_q};
				if (is_last(j_q, sz_c[olay_c])) begin
					j_d = '0;
					k_d = '0;
					if (olay_c == LAY_W'(1)) begin
						lay_d   = LAY_W'(1);
						state_d = ST_U_RD;
					end else begin
						lay_d   = olay_c - LAY_W'(1);
						state_d = ST_H_RD;
					end
				end else begin
					j_d     = j_q + NEU_W'(1);
					state_d = ST_O_RD;
				end
			end
			ST_H_RD: begin
				cmd.dlt_raddr = {lp1, k_q};
				cmd.w_addr    = wa_c;
				state_d       = ST_H_MUL;
			end
			ST_H_MUL: begin
				cmd.dlt_raddr = {lp1, k_q};
				cmd.w_addr    = wa_c;
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_DW;
				state_d       = ST_H_ACC;
			end
			ST_H_ACC: begin
				cmd.acc_en = 1'b1;
				if (is_last(k_q, sz_c[lp1])) begin
					state_d = ST_H_S;
				end else begin
					k_d     = k_q + NEU_W'(1);
					state_d = ST_H_RD;
				end
			end
			ST_H_S: begin
				cmd.sat_en    = 1'b1;
				cmd.act_raddr = {lay_q, j_q};
				state_d       = ST_H_MUL2;
			end
			ST_H_MUL2: begin
				cmd.act_raddr = {lay_q, j_q};
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_SLOPE;
				state_d       = ST_H_G;
			end
			ST_H_G: begin
				cmd.g_en = 1'b1;
				state_d  = ST_H_MUL3;
			end
			ST_H_MUL3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SG;
				state_d     = ST_H_WR;
			end
			ST_H_WR: begin
				cmd.dlt_we  = 1'b1;
				cmd.acc_clr = 1'b1;
				k_d         = '0;
				if (is_last(j_q, sz_c[lay_q])) begin
					j_d = '0;
					if (lay_q == LAY_W'(1)) begin
						state_d = ST_U_RD;
					end else begin
						lay_d   = lm1;
						state_d = ST_H_RD;
					end
				end else begin
					j_d     = j_q + NEU_W'(1);
					state_d = ST_H_RD;
				end
			end
			ST_U_RD: begin
				cmd.act_raddr = {lm1, k_q};
				cmd.dlt_raddr = {lay_q, j_q};
				cmd.w_addr    = wa_c;
				state_d       = ST_U_MUL;
			end
			ST_U_MUL: begin
				cmd.act_raddr = {lm1, k_q};
				cmd.dlt_raddr = {lay_q, j_q};
				cmd.w_addr    = wa_c;
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_AD;
				state_d       = ST_U_MUL2;
			end
			ST_U_MUL2: begin
				cmd.w_addr  = wa_c;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PL;
				state_d     = ST_U_WR;
			end
			ST_U_WR: begin
				cmd.w_addr = wa_c;
				cmd.w_we   = 1'b1;
				if (is_last(j_q, sz_c[lay_q])) begin
					j_d = '0;
					if (is_last(k_q, sz_c[lm1])) begin
						k_d = '0;
						if (lay_q == olay_c) begin
							state_d = ST_EM_RD;
						end else begin
							lay_d   = lp1;
							state_d = ST_U_RD;
						end
					end else begin
						k_d     = k_q + NEU_W'(1);
						state_d = ST_U_RD;
					end
				end else begin
					j_d     = j_q + NEU_W'(1);
					state_d = ST_U_RD;
				end
			end
			ST_EM_RD: begin
				state_d = ST_EM_OUT;
			end
			ST_EM_OUT: begin
				if (out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_sel  = train_q ? OUT_TRAIN : OUT_RUN;
					cmd.out_last = is_last(j_q, sz_c[olay_c]);
					if (is_last(j_q, sz_c[olay_c])) begin
						state_d = ST_IDLE;
					end else begin
						j_d     = j_q + NEU_W'(1);
						state_d = ST_EM_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			lay_q         <= '0;
			j_q           <= '0;
			k_q           <= '0;
			train_q       <= 1'b0;
			out_valid_q   <= 1'b0;
			layer_count_q <= 3'd3;
			for (int p = 0; p < MAX_LAYERS; p++) begin
				size_q[p] <= SZ_W'(8);
			end
			lr_q          <= 17'd6554;
			derr_q        <= 13'd41;
		end else begin
			state_q <= state_d;
			lay_q   <= lay_d;
			j_q     <= j_d;
			k_q     <= k_d;
			train_q <= train_d;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LAYER_COUNT:   layer_count_q <= cfg_data[2:0];
					CFG_SIZE_ZERO:     size_q[0] <= cfg_data[SZ_W-1:0];
					CFG_SIZE_ONE:      size_q[1] <= cfg_data[SZ_W-1:0];
					CFG_SIZE_TWO:      size_q[2] <= cfg_data[SZ_W-1:0];
					CFG_SIZE_THREE:    size_q[3] <= cfg_data[SZ_W-1:0];
					CFG_LEARNING_RATE: lr_q <= cfg_data[16:0];
					CFG_DESIRED_ERROR: derr_q <= cfg_data[12:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			idx_q <= item_index;
		end
	end

endmodule

FILE: rtl/mlp_backprop_trainer.sv
// Top level of the sigmoid network trainer: controller and datapath.
//
//  channel  direction  handshake            payload
//  input    in         in_valid / in_stall  action, item_index, item_value
//  result   out        out_valid / out_stall out_index, out_value, out_error, converged, last_result
//  config   in         cfg_we               cfg_index, cfg_data
//
// Writes are done as the item is accepted. A weight read passes the read and output states.
// Run computes each layer of the forward pass in turn, then emits each output.
// Train adds the output deltas, the hidden deltas and the weight updates;
// one shared multiplier and one read port per store set the pace.
// Reset clears control and loads register defaults; the stores are not cleared.
// A stalled result holds the controller at its emit step; nothing is dropped.
module mlp_backprop_trainer import mlpbt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            action,
	input  logic [7:0]            item_index,
	input  logic signed [15:0]    item_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            out_index,
	output logic signed [15:0]    out_value,
	output logic signed [13:0]    out_error,
	output logic                  converged,
	output logic                  last_result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t cmd;

	mlpbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.item_index(item_index),
		.item_value(item_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd)
	);

	mlpbt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.out_index  (out_index),
		.out_value  (out_value),
		.out_error  (out_error),
		.converged  (converged),
		.last_result(last_result)
	);

endmodule

FILE: tb/tb_mlp_backprop_trainer.sv
// Self-checking testbench for the sigmoid network trainer: random items, stalls, config phases.
module tb_mlp_backprop_trainer;
	import mlpbt_pkg::*;

	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	typedef struct {
		logic [2:0]  act;
		logic [7:0]  idx;
		logic [15:0] val;
	} item_t;

	typedef struct {
		logic [2:0]  idx;
		logic [15:0] val;
		logic [13:0] err;
		logic        conv;
		logic        last;
	} result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_stall;
	logic [2:0] action = 0;
	logic [7:0] item_index = 0;
	logic signed [15:0] item_value = 0;
	logic out_valid, out_stall = 0;
	logic [2:0] out_index;
	logic signed [15:0] out_value;
	logic signed [13:0] out_error;
	logic converged, last_result;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [CFG_DATA_W-1:0] cfg_data = 0;

	mlp_backprop_trainer u_top (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	item_t   pend_q[$];
	result_t net_results_q[$];
	int      fail_cnt = 0;
	bit      in_taken = 0;
	bit      quiet = 0;
	bit      send_hold = 0;
	int      send_gap = 0, recv_gap = 0;
	int      recv_hold_req = 0, recv_hold = 0;

	// network model state
	longint wts[256], inps[8], tgts[8], acts[24], dlts[24];
	logic [2:0]  m_layers = 3;
	logic [3:0]  m_size[4] = '{8, 8, 8, 8};
	logic [16:0] m_rate = 6554;
	logic [12:0] m_derr = 41;
	int          nl;
	int          sz[4];

	function automatic longint sat16(longint v);
		return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
	endfunction

	function automatic int wbase(int layer);
		int b = 0;
		for (int p = 0; p < layer && p + 1 < 4; p++) b += sz[p] * sz[p + 1];
		return b;
	endfunction

	function automatic int slot(int layer, int k);
		return ((layer - 1) * 8 + k) % 24;
	endfunction

	function automatic longint activation(int layer, int k);
		return layer == 0 ? inps[k % 8] : acts[slot(layer, k)];
	endfunction

	function automatic longint slope(longint o);
		return (o * (4096 - o)) >>> 12;
	endfunction

	function automatic void forward_pass();
		longint acc, net;
		int b, ix;
		nl = m_layers < 2 ? 2 : (m_layers > 4 ? 4 : m_layers);
		for (int i = 0; i < 4; i++) sz[i] = m_size[i] == 0 ? 1 : (m_size[i] > 8 ? 8 : m_size[i]);
		for (int l = 1; l < nl; l++) begin
			b = wbase(l - 1);
			for (int j = 0; j < sz[l]; j++) begin
				acc = 0;
				for (int k = 0; k < sz[l - 1]; k++)
					acc += activation(l - 1, k) * wts[(b + k * sz[l] + j) % 256];
				net = sat16(acc >>> 12);
				ix = int'(((net + 32768) * 256) >>> 16);
				if (ix > 255) ix = 255;
				acts[slot(l, j)] = longint'($signed(SIG_TABLE[ix]));
			end
		end
	endfunction

	function automatic void push_result(int j, longint v, longint e, bit c, bit l);
		result_t r;
		r.idx = j[2:0];
		r.val = v[15:0];
		r.err = e[13:0];
		r.conv = c;
		r.last = l;
		net_results_q.push_back(r);
	endfunction

	function automatic void predict_item(item_t it);
		longint v, o, e, sum, s, a, lr, dw;
		longint errs[8];
		bit conv = 1;
		int outl, b, w;
		v = longint'($signed(it.val));
		case (it.act)
			ACT_WR_WEIGHT: wts[it.idx] = v;
			ACT_WR_INPUT:  if (it.idx < 8) inps[it.idx] = v;
			ACT_WR_TARGET: if (it.idx < 8) tgts[it.idx] = v;
			ACT_RD_WEIGHT: push_result(0, wts[it.idx], 0, 0, 1);
			ACT_RUN: begin
				forward_pass();
				outl = nl - 1;
				for (int j = 0; j < sz[outl]; j++)
					push_result(j, activation(outl, j), 0, 0, j + 1 == sz[outl]);
			end
			ACT_TRAIN: begin
				forward_pass();
				outl = nl - 1;
				for (int j = 0; j < sz[outl]; j++) begin
					o = activation(outl, j);
					e = tgts[j] - o;
					e = e < -4096 ? -4096 : (e > 4096 ? 4096 : e);
					errs[j] = e;
					dlts[slot(outl, j)] = sat16((e * slope(o)) >>> 12);
					if (!(e == 0 || (e < 0 ? -e : e) < longint'(m_derr))) conv = 0;
				end
				for (int l = outl - 1; l >= 1; l--) begin
					b = wbase(l);
					for (int j = 0; j < sz[l]; j++) begin
						sum = 0;
						for (int k = 0; k < sz[l + 1]; k++)
							sum += dlts[slot(l + 1, k)] * wts[(b + j * sz[l + 1] + k) % 256];
						s = sat16(sum >>> 12);
						dlts[slot(l, j)] = sat16((s * slope(activation(l, j))) >>> 12);
					end
				end
				lr = m_rate > 65536 ? 65536 : longint'(m_rate);
				for (int l = 1; l <= outl; l++) begin
					b = wbase(l - 1);
					for (int k = 0; k < sz[l - 1]; k++) begin
						a = activation(l - 1, k);
						for (int j = 0; j < sz[l]; j++) begin
							w = (b + k * sz[l] + j) % 256;
							dw = (a * dlts[slot(l, j)] * lr) >>> 28;
							wts[w] = sat16(wts[w] + dw);
						end
					end
				end
				for (int j = 0; j < sz[outl]; j++)
					push_result(j, activation(outl, j), errs[j], conv, j + 1 == sz[outl]);
			end
			default: ;
		endcase
	endfunction

	// item driver
	always @(negedge clk) begin
		logic nv;
		item_t it;
		nv = 0;
		if (arst_n) begin
			if (in_valid && !in_taken) begin
				nv = 1;
			end else if (send_gap > 0) begin
				send_gap--;
			end else if (!send_hold && pend_q.size() > 0) begin
				if (!quiet && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(0, 13);
				end else begin
					it = pend_q.pop_front();
					action <= it.act;
					item_index <= it.idx;
					item_value <= it.val;
					nv = 1;
				end
			end
		end
		in_taken = 0;
		in_valid <= nv;
	end

	// result receiver
	always @(negedge clk) begin
		if (recv_hold_req > 0) begin
			recv_hold = recv_hold_req;
			recv_hold_req = 0;
		end
		if (recv_hold > 0) begin
			recv_hold--;
			out_stall <= 1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_stall <= 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			recv_gap = $urandom_range(0, 13);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		item_t it;
		result_t r;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_taken = 1;
				it.act = action;
				it.idx = item_index;
				it.val = item_value;
				predict_item(it);
			end
			if (out_valid && !out_stall) begin
				if (net_results_q.size() == 0) begin
					$display("%0t: unexpected result idx %0d val %0d", $time, out_index, out_value);
					fail_cnt++;
				end else begin
					r = net_results_q.pop_front();
					if (out_index !== r.idx || out_value !== r.val || out_error !== r.err
							|| converged !== r.conv || last_result !== r.last) begin
						$display("%0t: mismatch exp idx %0d val %0d err %0d conv %0d last %0d",
							$time, r.idx, $signed(r.val), $signed(r.err), r.conv, r.last);
						$display("%0t:          got idx %0d val %0d err %0d conv %0d last %0d",
							$time, out_index, out_value, out_error, converged, last_result);
						fail_cnt++;
					end
				end
			end
		end
	end

	task automatic add_item(logic [2:0] a, logic [7:0] i, logic [15:0] v);
		item_t it;
		it.act = a;
		it.idx = i;
		it.val = v;
		pend_q.push_back(it);
	endtask

	function automatic logic [15:0] rand_value();
		return $urandom_range(0, 1) ? 16'($urandom_range(0, 8191) - 4096) : 16'($urandom);
	endfunction

	// checked just after the falling edge, once the driver's updates have settled
	task automatic wait_drained();
		do begin
			@(negedge clk);
			#1;
		end while (pend_q.size() > 0 || in_valid || net_results_q.size() > 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= r;
		cfg_data <= d;
		case (r)
			CFG_LAYER_COUNT:   m_layers = d[2:0];
			CFG_SIZE_ZERO:     m_size[0] = d[3:0];
			CFG_SIZE_ONE:      m_size[1] = d[3:0];
			CFG_SIZE_TWO:      m_size[2] = d[3:0];
			CFG_SIZE_THREE:    m_size[3] = d[3:0];
			CFG_LEARNING_RATE: m_rate = d[16:0];
			CFG_DESIRED_ERROR: m_derr = d[12:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_items(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 33)      add_item(ACT_WR_WEIGHT, 8'($urandom), rand_value());
			else if (r < 45) add_item(ACT_WR_INPUT, 8'($urandom_range(0, 15)), rand_value());
			else if (r < 55) add_item(ACT_WR_TARGET, 8'($urandom_range(0, 15)),
				$urandom_range(0, 1) ? 16'($urandom_range(0, 4096)) : rand_value());
			else if (r < 70) add_item(ACT_RUN, 8'($urandom), 16'($urandom));
			else if (r < 86) add_item(ACT_TRAIN, 8'($urandom), 16'($urandom));
			else if (r < 96) add_item(ACT_RD_WEIGHT, 8'($urandom), 16'($urandom));
			else add_item($urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI, 8'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] lc[8] = '{2, 4, 0, 7, 3, 1, 5, 3};
		logic [CFG_DATA_W-1:0] rt[8] = '{1, 65536, 0, 131071, 6554, 30000, 65535, 6554};
		logic [CFG_DATA_W-1:0] de[8] = '{0, 4096, 8191, 41, 200, 1, 4095, 41};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// every store entry written before any read
		for (int i = 0; i < 256; i++) add_item(ACT_WR_WEIGHT, 8'(i), 16'($urandom_range(0, 4095) - 2048));
		for (int i = 0; i < 8; i++) begin
			add_item(ACT_WR_INPUT, 8'(i), rand_value());
			add_item(ACT_WR_TARGET, 8'(i), 16'($urandom_range(0, 4096)));
		end
		// directed corners
		add_item(ACT_WR_WEIGHT, 8'd255, 16'h8000);
		add_item(ACT_WR_WEIGHT, 8'd0, 16'h7FFF);
		add_item(ACT_RD_WEIGHT, 8'd255, 16'h0);
		add_item(ACT_RD_WEIGHT, 8'd0, 16'hFFFF);
		add_item(ACT_WR_INPUT, 8'd0, 16'h8000);
		add_item(ACT_WR_INPUT, 8'd7, 16'h7FFF);
		add_item(ACT_WR_INPUT, 8'd200, 16'h1234);
		add_item(ACT_WR_TARGET, 8'd9, 16'h1000);
		add_item(ACT_WR_TARGET, 8'd0, 16'h8000);
		add_item(ACT_WR_TARGET, 8'd7, 16'h7FFF);
		add_item(ACT_RUN, 8'd0, 16'h0);
		add_item(ACT_TRAIN, 8'd0, 16'h0);
		add_item(ACT_SPARE_LO, 8'd0, 16'h0);
		add_item(ACT_SPARE_HI, 8'hFF, 16'hFFFF);
		add_item(ACT_TRAIN, 8'hFF, 16'hFFFF);
		add_item(ACT_RD_WEIGHT, 8'd17, 16'h0);
		wait_drained();
		for (int ph = 0; ph < 8; ph++) begin
			quiet = (ph == 7);
			write_reg(CFG_LAYER_COUNT, lc[ph]);
			for (int s = 0; s < 4; s++)
				write_reg(cfg_reg_t'(CFG_SIZE_ZERO + s), ph == 4 ? 17'd8 :
					(ph == 3 ? 17'd0 : (ph == 5 ? 17'd15 : 17'($urandom_range(0, 3) == 0 ? 9 : $urandom_range(1, 4)))));
			write_reg(CFG_LEARNING_RATE, rt[ph]);
			write_reg(CFG_DESIRED_ERROR, de[ph]);
			if (ph == 2) begin
				// receiver holds off while the sender keeps offering runs
				recv_hold_req = 1500;
				for (int i = 0; i < 8; i++) add_item(ACT_RUN, 8'd0, 16'd0);
			end
			random_items(ph == 4 ? 6 : 10);
			if (ph == 1) begin
				repeat (150) @(negedge clk);
				send_hold = 1;
				do begin
					@(negedge clk);
					#1;
				end while (net_results_q.size() > 0 || in_valid);
				send_hold = 0;
			end
			random_items(ph == 4 ? 4 : 10);
			wait_drained();
		end
		if (fail_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#50000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
